@@ design/hpk_pkg.sv @@
// Shared types and constants for the heatmap peak keypoint finder.
`timescale 1ns / 1ps

package hpk_pkg;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X_Q8     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y_Q8     = 3'd5;

  // Register widths and values after reset.
  localparam int THRESH_W = 15;
  localparam int GEOM_W   = 9;
  localparam int CHCFG_W  = 7;
  localparam int SCALE_W  = 16;

  localparam logic [THRESH_W-1:0] THRESH_RST   = 15'd1;
  localparam logic [GEOM_W-1:0]   WIDTH_RST    = 9'd64;
  localparam logic [GEOM_W-1:0]   HEIGHT_RST   = 9'd64;
  localparam logic [CHCFG_W-1:0]  CHANNELS_RST = 7'd16;
  localparam logic [SCALE_W-1:0]  SCALE_RST    = 16'd1024;

  // Result field widths.
  localparam int CLASS_W = 6;
  localparam int GRID_W  = 8;
  localparam int IMAGE_W = 16;
  localparam int CONF_W  = 15;

  // Collect samples, or shift the per-channel peaks out one per transfer.
  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } hpk_state_t;

  // Control for one cell of the peak chain.
  typedef struct packed {
    logic clear;   // restart of the frame: drop the kept peak
    logic shift;   // take the neighbour's peak
    logic update;  // compare the current sample against the kept peak
  } hpk_cell_ctrl_t;

endpackage

@@ design/hpk_cell.sv @@
// One cell of the peak chain: keeps the peak value and position of one channel.
`timescale 1ns / 1ps

module hpk_cell import hpk_pkg::*; #(
  parameter int PEAK_W     = 15,
  parameter int COORD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hpk_cell_ctrl_t        ctrl,
  input  logic [PEAK_W-1:0]     sample_val,
  input  logic [COORD_BITS-1:0] sample_col,
  input  logic [COORD_BITS-1:0] sample_row,
  input  logic [PEAK_W-1:0]     nb_val,
  input  logic [COORD_BITS-1:0] nb_col,
  input  logic [COORD_BITS-1:0] nb_row,
  output logic [PEAK_W-1:0]     peak_val,
  output logic [COORD_BITS-1:0] peak_col,
  output logic [COORD_BITS-1:0] peak_row
);

  logic [PEAK_W-1:0]     val_r, val_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;

  // A strictly greater sample replaces the kept peak, so the first peak wins.
  always_comb begin
    val_nxt = val_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (ctrl.clear) begin
      val_nxt = '0;
      col_nxt = '0;
      row_nxt = '0;
    end else if (ctrl.shift) begin
      val_nxt = nb_val;
      col_nxt = nb_col;
      row_nxt = nb_row;
    end else if (ctrl.update && (sample_val > val_r)) begin
      val_nxt = sample_val;
      col_nxt = sample_col;
      row_nxt = sample_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      val_r <= val_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign peak_val = val_r;
  assign peak_col = col_r;
  assign peak_row = row_r;

endmodule

@@ design/heatmap_peak_keypoint_finder.sv @@
// Top level of the heatmap peak keypoint finder: counters, peak chain and result stage.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake          Payload
//  in_       in         in_valid/in_stall  in_heat_value
//  out_      out        out_valid/out_stall keypoint_id, found, grid, image, confidence, last
//  cfg_      in         cfg_we             cfg_index, cfg_wdata
//
//  One sample is taken per cycle while a frame is being collected.
//  The last sample of a frame starts the drain: the chain of cells shifts one peak
//  into the output register per transfer. in_stall is high for the whole drain.
//  Reset and any write of the geometry registers clear the peaks and counters.

module heatmap_peak_keypoint_finder import hpk_pkg::*; #(
  parameter int MAX_CHANNELS = 16,
  parameter int COORD_BITS   = 8,
  parameter int HEAT_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Sample channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [HEAT_BITS-1:0] in_heat_value,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [CLASS_W-1:0]          out_keypoint_id,
  output logic                        out_found,
  output logic [GRID_W-1:0]           out_grid_x,
  output logic [GRID_W-1:0]           out_grid_y,
  output logic [IMAGE_W-1:0]          out_image_x,
  output logic [IMAGE_W-1:0]          out_image_y,
  output logic [CONF_W-1:0]           out_confidence,
  output logic                        out_last_in_run,
  // Configuration port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int PEAK_W = HEAT_BITS - 1;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int GW     = (COORD_BITS + 1 > GEOM_W) ? COORD_BITS + 1 : GEOM_W;
  localparam int CMP_W  = ((HEAT_BITS > THRESH_W) ? HEAT_BITS : THRESH_W) + 1;
  localparam int PROD_W = COORD_BITS + SCALE_W;
  localparam int CW     = (PEAK_W > CONF_W) ? PEAK_W : CONF_W;
  localparam int NCH_W  = CHCFG_W + 1;

  // Configuration registers.
  logic [THRESH_W-1:0] thresh_r;
  logic [GEOM_W-1:0]   width_r;
  logic [GEOM_W-1:0]   height_r;
  logic [CHCFG_W-1:0]  chans_r;
  logic [SCALE_W-1:0]  scale_x_r;
  logic [SCALE_W-1:0]  scale_y_r;
  logic                geom_wr;

  assign geom_wr = cfg_we && ((cfg_index == REG_MAP_WIDTH) ||
                              (cfg_index == REG_MAP_HEIGHT) ||
                              (cfg_index == REG_CHANNEL_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESH_RST;
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      chans_r   <= CHANNELS_RST;
      scale_x_r <= SCALE_RST;
      scale_y_r <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAT_THRESHOLD: thresh_r  <= cfg_wdata[THRESH_W-1:0];
        REG_MAP_WIDTH:      width_r   <= cfg_wdata[GEOM_W-1:0];
        REG_MAP_HEIGHT:     height_r  <= cfg_wdata[GEOM_W-1:0];
        REG_CHANNEL_COUNT:  chans_r   <= cfg_wdata[CHCFG_W-1:0];
        REG_SCALE_X_Q8:     scale_x_r <= cfg_wdata;
        REG_SCALE_Y_Q8:     scale_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective geometry: each count clamped to at least one and to its maximum.
  logic [NCH_W-1:0] nch;
  logic [GW-1:0]    eff_w;
  logic [GW-1:0]    eff_h;

  always_comb begin
    if (chans_r == '0) begin
      nch = NCH_W'(1);
    end else if (NCH_W'(chans_r) > NCH_W'(MAX_CHANNELS)) begin
      nch = NCH_W'(MAX_CHANNELS);
    end else begin
      nch = NCH_W'(chans_r);
    end
    if (width_r == '0) begin
      eff_w = GW'(1);
    end else if (GW'(width_r) > (GW'(1) << COORD_BITS)) begin
      eff_w = GW'(1) << COORD_BITS;
    end else begin
      eff_w = GW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = GW'(1);
    end else if (GW'(height_r) > (GW'(1) << COORD_BITS)) begin
      eff_h = GW'(1) << COORD_BITS;
    end else begin
      eff_h = GW'(height_r);
    end
  end

  // Control state.
  hpk_state_t            state_r, state_nxt;
  logic [CH_W-1:0]       chan_pos_r;
  logic [COORD_BITS-1:0] col_pos_r;
  logic [COORD_BITS-1:0] row_pos_r;
  logic [CH_W-1:0]       drain_cnt_r;
  logic                  out_valid_r;

  logic in_xfer;
  logic chan_wrap;
  logic col_wrap;
  logic row_wrap;
  logic frame_end;
  logic drain_active;
  logic load;
  logic drain_last;

  assign in_xfer    = in_valid && !in_stall;
  assign chan_wrap  = (NCH_W'(chan_pos_r) + NCH_W'(1)) >= nch;
  assign col_wrap   = (GW'(col_pos_r) + GW'(1)) >= eff_w;
  assign row_wrap   = (GW'(row_pos_r) + GW'(1)) >= eff_h;
  assign frame_end  = in_xfer && chan_wrap && col_wrap && row_wrap;
  assign load       = drain_active && (!out_valid_r || !out_stall);
  assign drain_last = (NCH_W'(drain_cnt_r) + NCH_W'(1)) >= nch;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: if (frame_end) state_nxt = ST_DRAIN;
      ST_DRAIN:   if (load && drain_last) state_nxt = ST_COLLECT;
      default:    state_nxt = ST_COLLECT;
    endcase
    if (geom_wr) state_nxt = ST_COLLECT;
  end

  // State outputs.
  always_comb begin
    case (state_r)
      ST_COLLECT: drain_active = 1'b0;
      ST_DRAIN:   drain_active = 1'b1;
      default:    drain_active = 1'b0;
    endcase
  end

  assign in_stall = drain_active;

  // Position counters, channel fastest.
  always_ff @(posedge clk) begin
    if (!rst_n || geom_wr) begin
      state_r     <= ST_COLLECT;
      chan_pos_r  <= '0;
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      drain_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        if (chan_wrap) begin
          chan_pos_r <= '0;
          if (col_wrap) begin
            col_pos_r <= '0;
            row_pos_r <= row_wrap ? '0 : row_pos_r + 1'b1;
          end else begin
            col_pos_r <= col_pos_r + 1'b1;
          end
        end else begin
          chan_pos_r <= chan_pos_r + 1'b1;
        end
      end
      if (frame_end) begin
        drain_cnt_r <= '0;
      end else if (load) begin
        drain_cnt_r <= drain_cnt_r + 1'b1;
      end
    end
  end

  // Threshold: samples below it count as zero; what remains is never negative.
  logic [PEAK_W-1:0] sample_val;

  always_comb begin
    if ($signed(CMP_W'(in_heat_value)) < $signed({1'b0, (CMP_W-1)'(thresh_r)})) begin
      sample_val = '0;
    end else begin
      sample_val = in_heat_value[PEAK_W-1:0];
    end
  end

  // Chain of cells; cell 0 is the head, the tail takes in zeros while draining.
  logic [PEAK_W-1:0]     cell_val [MAX_CHANNELS+1];
  logic [COORD_BITS-1:0] cell_col [MAX_CHANNELS+1];
  logic [COORD_BITS-1:0] cell_row [MAX_CHANNELS+1];

  assign cell_val[MAX_CHANNELS] = '0;
  assign cell_col[MAX_CHANNELS] = '0;
  assign cell_row[MAX_CHANNELS] = '0;

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
    hpk_cell_ctrl_t ctrl;

    assign ctrl.clear  = geom_wr;
    assign ctrl.shift  = load;
    assign ctrl.update = in_xfer && (chan_pos_r == CH_W'(i));

    hpk_cell #(
      .PEAK_W     (PEAK_W),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .sample_val (sample_val),
      .sample_col (col_pos_r),
      .sample_row (row_pos_r),
      .nb_val     (cell_val[i+1]),
      .nb_col     (cell_col[i+1]),
      .nb_row     (cell_row[i+1]),
      .peak_val   (cell_val[i]),
      .peak_col   (cell_col[i]),
      .peak_row   (cell_row[i])
    );
  end

  // Result fields from the head cell.
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [PROD_W-1:0] shr_x, shr_y;
  logic [CW-1:0]     conf_ext;

  assign prod_x   = PROD_W'(cell_col[0]) * PROD_W'(scale_x_r);
  assign prod_y   = PROD_W'(cell_row[0]) * PROD_W'(scale_y_r);
  assign shr_x    = prod_x >> 8;
  assign shr_y    = prod_y >> 8;
  assign conf_ext = CW'(cell_val[0]);

  logic [CLASS_W-1:0] class_r;
  logic               found_r;
  logic [GRID_W-1:0]  grid_x_r, grid_y_r;
  logic [IMAGE_W-1:0] image_x_r, image_y_r;
  logic [CONF_W-1:0]  conf_r;
  logic               last_r;

  // Output register: filled by each shift of the chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      class_r   <= CLASS_W'(drain_cnt_r);
      found_r   <= (cell_col[0] != '0) && (cell_row[0] != '0);
      grid_x_r  <= GRID_W'(cell_col[0]);
      grid_y_r  <= GRID_W'(cell_row[0]);
      image_x_r <= (shr_x > PROD_W'(65535)) ? {IMAGE_W{1'b1}} : shr_x[IMAGE_W-1:0];
      image_y_r <= (shr_y > PROD_W'(65535)) ? {IMAGE_W{1'b1}} : shr_y[IMAGE_W-1:0];
      conf_r    <= (conf_ext > CW'(32767)) ? {CONF_W{1'b1}} : conf_ext[CONF_W-1:0];
      last_r    <= drain_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_keypoint_id = class_r;
  assign out_found       = found_r;
  assign out_grid_x      = grid_x_r;
  assign out_grid_y      = grid_y_r;
  assign out_image_x     = image_x_r;
  assign out_image_y     = image_y_r;
  assign out_confidence  = conf_r;
  assign out_last_in_run = last_r;

  // A result only appears after a shift of the chain during the drain.
  a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DRAIN)
    else $error("result appeared outside the drain");

  // The drain counter never reaches the channel count.
  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (NCH_W'(drain_cnt_r) < nch))
    else $error("drain counter ran past the channel count");

  // While draining, the position counters already stand at the start of a frame.
  a_drain_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |->
      (chan_pos_r == '0) && (col_pos_r == '0) && (row_pos_r == '0))
    else $error("position counters not restarted at frame end");

  // The drain is entered only by the last sample of a frame.
  a_drain_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) && ($past(state_r) == ST_COLLECT) |-> $past(frame_end))
    else $error("drain started without a frame end");

endmodule
